// ===== src/mrqd_pkg.sv =====
// Package for the message ring queue with duplicate skipping.
// Holds the default sizes, the field widths, the action and status codes, the
// sequencer states and the store control struct. Depends on nothing.
`timescale 1ns / 1ps

package mrqd_pkg;

   // default geometry of the message store
   localparam int SLOTS_DEFAULT      = 16;
   localparam int SLOT_BYTES_DEFAULT = 64;

   // message layout: length in bytes 0 (low) and 1 (high), type in byte 3
   localparam int TYPE_BYTE = 3;
   localparam int LEN_SHIFT = 8;

   // fixed field widths of the transfer payloads
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;
   localparam int OFFSET_W = 6;
   localparam int USED_W   = 4;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [ACTION_W-1:0] {
      ACT_APPEND = 2'd0,
      ACT_POP    = 2'd1,
      ACT_READ   = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_TOO_LONG = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_DROPPED  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LEN_RD,
      ST_LEN,
      ST_BYTE_RD,
      ST_BYTE_CMP,
      ST_POP_DONE
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

// ===== src/mrqd_store.sv =====
// Byte store of the message ring queue: one write port, two read ports,
// read data registered and held while no read is enabled. Uses mrqd_pkg.
`timescale 1ns / 1ps

module mrqd_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                clock,
   input  mrqd_pkg::mem_ctl_type ctl,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [7:0]          wr_data,
   input  logic [ADDR_W-1:0]   rd_addr_a,
   input  logic [ADDR_W-1:0]   rd_addr_b,
   output logic [7:0]          rd_data_a,
   output logic [7:0]          rd_data_b
);
   import mrqd_pkg::*;

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_a_ff;
   logic [7:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== src/message_ring_queue_dedupe.sv =====
// Top level of the message ring queue with duplicate skipping on pop.
// Depends on mrqd_pkg and mrqd_store.
`timescale 1ns / 1ps

// A ring of SLOTS message slots of SLOT_BYTES bytes each, one slot always kept
// empty, so up to SLOTS-1 messages wait. Each request transfer is one action
// (req_tuser): append a byte (req_tlast commits the message), pop the next
// message, or read one stored byte. Every request gives exactly one response
// transfer with a status in rsp_tuser. Committing into a full queue drops the
// oldest message first (status 3); a message longer than a slot is rejected
// (status 2) and staging starts over. A pop with dedupe set skips each message
// whose type byte and bytes 3 up to its length (bytes 0/1, clamped to the slot)
// match a newer queued message, stopping early at a common zero byte. One item
// is worked on at a time. A dedupe pop goes from ST_EXEC through, for every
// candidate message, ST_LEN_RD and ST_LEN to fetch its length and ST_BYTE_RD
// and ST_BYTE_CMP for each byte compared against each newer message, to
// ST_POP_DONE; those comparisons run over the two read ports of the single
// byte store, one byte pair at a time. The response waits in an output
// register, so a new request is taken as soon as the block is idle even if
// the previous response is still held. Bytes that were never written read as
// undefined.
module message_ring_queue_dedupe #(
   parameter int SLOTS      = mrqd_pkg::SLOTS_DEFAULT,
   parameter int SLOT_BYTES = mrqd_pkg::SLOT_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // data_byte[7:0], dedupe[8], slot[12:9], offset[18:13], zero fill [23:19]
   input  logic [mrqd_pkg::REQ_DATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [mrqd_pkg::ACTION_W-1:0]   req_tuser,
   input  logic                            req_tlast,
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_slot[3:0], read_byte[11:4], used_count[15:12]
   output logic [mrqd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [mrqd_pkg::STATUS_W-1:0]   rsp_tuser
);
   import mrqd_pkg::*;

   localparam int DEPTH  = SLOTS * SLOT_BYTES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PTR_W  = $clog2(SLOTS);
   localparam int BYTE_W = $clog2(SLOT_BYTES);
   localparam int LEN_W  = $clog2(SLOT_BYTES + 2);   // staged count saturates at SLOT_BYTES+1
   localparam int END_W  = $clog2(SLOT_BYTES + 1);   // compare end, up to SLOT_BYTES
   localparam int CNT_W  = PTR_W + 1;

   localparam logic [PTR_W-1:0]  PTR_MAX = PTR_W'(SLOTS - 1);
   localparam logic [ADDR_W-1:0] SB_A    = ADDR_W'(SLOT_BYTES);
   localparam logic [LEN_W-1:0]  SB_L    = LEN_W'(SLOT_BYTES);
   localparam logic [END_W-1:0]  SB_E    = END_W'(SLOT_BYTES);
   localparam logic [BYTE_W-1:0] TYPE_K  = BYTE_W'(TYPE_BYTE);

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      return (p == PTR_MAX) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [ADDR_W-1:0] byte_addr(input logic [PTR_W-1:0] p,
                                                   input logic [BYTE_W-1:0] k);
      return ADDR_W'(p) * SB_A + ADDR_W'(k);
   endfunction

   // unpack the request
   logic [7:0]          req_data_byte;
   logic                req_dedupe;
   logic [SLOT_W-1:0]   req_slot;
   logic [OFFSET_W-1:0] req_offset;
   logic                req_in_range;

   assign req_data_byte = req_tdata[7:0];
   assign req_dedupe    = req_tdata[8];
   assign req_slot      = req_tdata[12:9];
   assign req_offset    = req_tdata[18:13];
   assign req_in_range  = (32'(req_slot) < SLOTS) && (32'(req_offset) < SLOT_BYTES);

   // control state
   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  in_ptr_ff, in_ptr_in;
   logic [PTR_W-1:0]  out_ptr_ff, out_ptr_in;
   logic [LEN_W-1:0]  staged_ff, staged_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // item and walk registers (payload, no reset)
   action_type        act_ff;
   logic [7:0]        data_ff;
   logic              last_ff;
   logic              dedupe_ff;
   logic              in_range_ff;
   logic [PTR_W-1:0]  cand_ff, cand_in;     // message under test
   logic [PTR_W-1:0]  nxt_ff, nxt_in;       // newer message compared against
   logic [BYTE_W-1:0] k_ff, k_in;           // byte under comparison
   logic [END_W-1:0]  end_ff, end_in;       // clamped message length

   // response register
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic [USED_W-1:0]   rsp_used_ff, rsp_used_in;

   // store interface
   mem_ctl_type       mem_ctl;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [ADDR_W-1:0] rd_addr_b;
   logic [7:0]        rd_data_a;
   logic [7:0]        rd_data_b;

   logic              emit;
   logic              emit_ok;
   logic [PTR_W-1:0]  target;
   logic [LEN_W-1:0]  staged_sat;
   logic [15:0]       msg_len;
   logic [END_W-1:0]  k_next_e;
   logic [CNT_W-1:0]  waiting;

   mrqd_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock     (clock),
      .ctl       (mem_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (data_ff),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // a response may load when the output register is empty or draining
   assign emit_ok    = !rsp_valid_ff || rsp_tready;
   assign target     = next_slot(in_ptr_ff);
   assign staged_sat = (staged_ff <= SB_L) ? staged_ff + LEN_W'(1) : staged_ff;
   assign msg_len    = {8'd0, rd_data_a} | (16'(rd_data_b) << LEN_SHIFT);
   assign k_next_e   = END_W'(k_ff) + END_W'(1);

   always_comb begin
      state_in      = state_ff;
      in_ptr_in     = in_ptr_ff;
      out_ptr_in    = out_ptr_ff;
      staged_in     = staged_ff;
      cand_in       = cand_ff;
      nxt_in        = nxt_ff;
      k_in          = k_ff;
      end_in        = end_ff;
      emit          = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_slot_in   = '0;
      rsp_byte_in   = 8'd0;
      mem_ctl       = '0;
      wr_addr       = '0;
      rd_addr_a     = '0;
      rd_addr_b     = '0;

      case (state_ff)
         ST_IDLE: begin
            // fetch the read byte while the request transfers
            mem_ctl.rd_en = 1'b1;
            rd_addr_a     = byte_addr(PTR_W'(req_slot), BYTE_W'(req_offset));
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (act_ff)
               ACT_APPEND: begin
                  if (emit_ok) begin
                     emit     = 1'b1;
                     state_in = ST_IDLE;
                     if (staged_ff < SB_L) begin
                        mem_ctl.wr_en = 1'b1;
                        wr_addr       = byte_addr(target, BYTE_W'(staged_ff));
                     end
                     if (last_ff) begin
                        // full queue: drop the oldest message before the commit
                        if (target == out_ptr_ff) begin
                           out_ptr_in    = next_slot(out_ptr_ff);
                           rsp_status_in = STAT_DROPPED;
                        end
                        if (staged_sat <= SB_L) begin
                           in_ptr_in = target;
                        end else begin
                           rsp_status_in = STAT_TOO_LONG;
                        end
                        staged_in = '0;
                     end else begin
                        staged_in = staged_sat;
                     end
                  end
               end
               ACT_POP: begin
                  if (in_ptr_ff == out_ptr_ff) begin
                     if (emit_ok) begin
                        emit          = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                        state_in      = ST_IDLE;
                     end
                  end else if (!dedupe_ff || next_slot(out_ptr_ff) == in_ptr_ff) begin
                     if (emit_ok) begin
                        emit        = 1'b1;
                        out_ptr_in  = next_slot(out_ptr_ff);
                        rsp_slot_in = SLOT_W'(next_slot(out_ptr_ff));
                        state_in    = ST_IDLE;
                     end
                  end else begin
                     cand_in  = next_slot(out_ptr_ff);
                     state_in = ST_LEN_RD;
                  end
               end
               ACT_READ: begin
                  if (emit_ok) begin
                     emit        = 1'b1;
                     rsp_byte_in = in_range_ff ? rd_data_a : 8'd0;
                     state_in    = ST_IDLE;
                  end
               end
               default: begin
                  if (emit_ok) begin
                     emit     = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end
         ST_LEN_RD: begin
            mem_ctl.rd_en = 1'b1;
            rd_addr_a     = byte_addr(cand_ff, BYTE_W'(0));
            rd_addr_b     = byte_addr(cand_ff, BYTE_W'(1));
            state_in      = ST_LEN;
         end
         ST_LEN: begin
            // clamp the length to the slot and start at the first newer message
            end_in   = (32'(msg_len) > SLOT_BYTES) ? SB_E : END_W'(msg_len);
            nxt_in   = next_slot(cand_ff);
            k_in     = TYPE_K;
            state_in = ST_BYTE_RD;
         end
         ST_BYTE_RD: begin
            mem_ctl.rd_en = 1'b1;
            rd_addr_a     = byte_addr(cand_ff, k_ff);
            rd_addr_b     = byte_addr(nxt_ff, k_ff);
            state_in      = ST_BYTE_CMP;
         end
         ST_BYTE_CMP: begin
            if (rd_data_a != rd_data_b) begin
               // no match with this newer message: try the next one, or pop the candidate if none is left
               if (nxt_ff == in_ptr_ff) begin
                  state_in = ST_POP_DONE;
               end else begin
                  nxt_in   = next_slot(nxt_ff);
                  k_in     = TYPE_K;
                  state_in = ST_BYTE_RD;
               end
            end else if (rd_data_a == 8'd0 || k_next_e >= end_ff) begin
               // duplicated by a newer message: skip the candidate
               cand_in = next_slot(cand_ff);
               if (next_slot(cand_ff) == in_ptr_ff) begin
                  state_in = ST_POP_DONE;
               end else begin
                  state_in = ST_LEN_RD;
               end
            end else begin
               k_in     = k_ff + BYTE_W'(1);
               state_in = ST_BYTE_RD;
            end
         end
         ST_POP_DONE: begin
            if (emit_ok) begin
               emit        = 1'b1;
               out_ptr_in  = cand_ff;
               rsp_slot_in = SLOT_W'(cand_ff);
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // messages waiting after this step, from the updated pointers
   assign waiting = (in_ptr_in >= out_ptr_in) ?
                    CNT_W'(in_ptr_in) - CNT_W'(out_ptr_in) :
                    CNT_W'(in_ptr_in) + CNT_W'(SLOTS) - CNT_W'(out_ptr_in);
   assign rsp_used_in  = USED_W'(waiting);
   assign rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_ptr_ff    <= '0;
         out_ptr_ff   <= '0;
         staged_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_ptr_ff    <= in_ptr_in;
         out_ptr_ff   <= out_ptr_in;
         staged_ff    <= staged_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the accepted item and update the walk registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         act_ff      <= action_type'(req_tuser);
         data_ff     <= req_data_byte;
         last_ff     <= req_tlast;
         dedupe_ff   <= req_dedupe;
         in_range_ff <= req_in_range;
      end
      cand_ff <= cand_in;
      nxt_ff  <= nxt_in;
      k_ff    <= k_in;
      end_ff  <= end_in;
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_byte_ff   <= rsp_byte_in;
         rsp_used_ff   <= rsp_used_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_used_ff, rsp_byte_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== src/mrqd_checker.sv =====
// Port-level checks for the message ring queue, bound to the top level.
// Depends on mrqd_pkg and message_ring_queue_dedupe.
`timescale 1ns / 1ps

module mrqd_port_checks (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mrqd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [mrqd_pkg::STATUS_W-1:0]   rsp_tuser
);
   import mrqd_pkg::*;

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // one item at a time: busy right after a request transfer
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is in progress");

   // an empty-queue pop reports no waiting messages
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_EMPTY |-> rsp_tdata[15:12] == 4'd0)
      else $error("empty status with messages waiting");

   // only a successful pop or a read returns a slot or a byte
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STAT_OK |-> rsp_tdata[11:0] == 12'd0)
      else $error("slot or byte reported with a non-ok status");

endmodule

bind message_ring_queue_dedupe mrqd_port_checks u_mrqd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
